### hdl/retry_packet_header_parser_assert.svh
// ----------------------------------------------------------------------------
// retry packet header parser assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef RETRY_PACKET_HEADER_PARSER_ASSERT_SVH
`define RETRY_PACKET_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define RPHP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define RPHP_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RPHP_ASSERT(name, clk, rst_n, prop, msg)
`define RPHP_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

### hdl/rphp_pkg.sv
// ----------------------------------------------------------------------------
// rphp_pkg
// Shared types and constants of the retry packet header parser.
// ----------------------------------------------------------------------------
package rphp_pkg;

    // label of one result word
    typedef enum logic [3:0] {
        KIND_FIRST    = 4'd0,
        KIND_VERSION  = 4'd1,
        KIND_DEST_LEN = 4'd2,
        KIND_DEST_ID  = 4'd3,
        KIND_SRC_LEN  = 4'd4,
        KIND_SRC_ID   = 4'd5,
        KIND_TOKEN    = 4'd6,
        KIND_TAG      = 4'd7,
        KIND_DISCARD  = 4'd8,
        KIND_STATUS   = 4'd9
    } t_kind;

    // packet status code
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_NOT_LONG    = 3'd2,
        ST_NOT_RETRY   = 3'd3,
        ST_ID_TOO_LONG = 3'd4,
        ST_OVERSIZE    = 3'd5
    } t_status;

    // header error bit positions
    localparam int unsigned ERR_NOT_LONG    = 0;
    localparam int unsigned ERR_NOT_RETRY   = 1;
    localparam int unsigned ERR_ID_TOO_LONG = 2;
    localparam int unsigned ERR_W           = 3;

    // header format
    localparam logic [7:0]  LONG_HEADER_BIT  = 8'h80;
    localparam logic [1:0]  RETRY_TYPE       = 2'h3;
    localparam int unsigned MIN_HEADER_BYTES = 7;

    // input word held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // one result word
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [31:0] version_word;
        logic [7:0]  dest_id_length;
        logic [7:0]  source_id_length;
        logic [11:0] token_length;
        t_status     status_code;
        logic        last_result;
    } t_result;

endpackage

### hdl/rphp_in_reg.sv
// ----------------------------------------------------------------------------
// rphp_in_reg
// Input register stage; takes a new word when empty or when the held one is consumed.
// ----------------------------------------------------------------------------
module rphp_in_reg import rphp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_ready,
    output logic       o_word_valid,
    output t_in_word   o_word,
    input  logic       i_take
);

    logic     r_valid;
    t_in_word r_word;

    // free when empty or when the parser consumes the held word
    assign o_ready      = !r_valid || i_take;
    assign o_word_valid = r_valid;
    assign o_word       = r_word;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= '{data_byte: i_data_byte, last_byte: i_last_byte};
        end
    end

endmodule

### hdl/rphp_core.sv
// ----------------------------------------------------------------------------
// rphp_core
// Header capture, byte labelling, tag delay line and end-of-packet flush.
// ----------------------------------------------------------------------------
`include "retry_packet_header_parser_assert.svh"

module rphp_core import rphp_pkg::*; #(
    parameter int unsigned MAX_CID_BYTES    = 20,
    parameter int unsigned TAG_BYTES        = 16,
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_word_valid,
    input  t_in_word i_word,
    input  logic     i_slot_free,
    output logic     o_take,
    output logic     o_res_valid,
    output t_result  o_res
);

    // counter holds every position up to just past the size limit and the header
    localparam int unsigned CntW =
        ($clog2(MAX_PACKET_BYTES + 2) > 10) ? $clog2(MAX_PACKET_BYTES + 2) : 10;
    localparam int unsigned RemW = $clog2(TAG_BYTES + 1);
    localparam int unsigned IdxW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;

    localparam logic [CntW-1:0] CntMax        = '1;
    localparam logic [CntW-1:0] PktMax        = CntW'(MAX_PACKET_BYTES);
    localparam logic [CntW-1:0] TagLen        = CntW'(TAG_BYTES);
    localparam logic [CntW-1:0] MinLen        = CntW'(MIN_HEADER_BYTES);
    localparam logic [CntW-1:0] PosFirst      = CntW'(0);
    localparam logic [CntW-1:0] PosVersionEnd = CntW'(4);
    localparam logic [CntW-1:0] PosDestLen    = CntW'(5);
    localparam logic [RemW-1:0] TagRem        = RemW'(TAG_BYTES);
    localparam logic [7:0]      CidMax        = 8'(MAX_CID_BYTES);

    // delay line, newest at entry zero
    logic [7:0]      r_line_byte [TAG_BYTES];
    t_kind           r_line_kind [TAG_BYTES];

    logic [CntW-1:0] r_count;
    logic [31:0]     r_version;
    logic [7:0]      r_dest_len;
    logic [7:0]      r_src_len;
    logic [ERR_W-1:0] r_hdr_err;
    logic            r_oversize;
    logic            r_flush;
    logic [RemW-1:0] r_rem;

    logic [31:0]     n_version;
    logic [7:0]      n_dest_len;
    logic [7:0]      n_src_len;
    logic [ERR_W-1:0] n_hdr_err;
    logic            n_oversize;

    logic [7:0]      in_byte;
    logic            hdr_err;
    logic [CntW-1:0] dest_len_ext;
    logic [CntW-1:0] src_len_ext;
    logic [CntW-1:0] dest_end;
    logic [CntW-1:0] src_len_pos;
    logic [CntW-1:0] src_end;
    logic [CntW-1:0] new_len;
    logic [CntW-1:0] hdr_need;
    logic [CntW-1:0] full_need;
    logic [IdxW-1:0] rem_idx;
    logic            flush_step;
    t_kind           in_kind;
    t_status         stat_code;
    logic [11:0]     stat_token;

    assign in_byte      = i_word.data_byte;
    assign hdr_err      = |r_hdr_err;
    assign dest_len_ext = CntW'(r_dest_len);
    assign src_len_ext  = CntW'(r_src_len);
    assign dest_end     = PosDestLen + dest_len_ext;
    assign src_len_pos  = dest_end + CntW'(1);
    assign src_end      = src_len_pos + src_len_ext;
    assign new_len      = (r_count == CntMax) ? r_count : r_count + CntW'(1);
    assign rem_idx      = IdxW'(r_rem - RemW'(1));

    // handshake with the input register and the output register
    assign o_take     = i_word_valid && !r_flush && i_slot_free;
    assign flush_step = r_flush && i_slot_free;

    // label of the incoming byte, fixed once it is in the line
    always_comb begin
        if (r_count >= PktMax) begin
            in_kind = KIND_DISCARD;
        end else if (hdr_err) begin
            in_kind = KIND_DISCARD;
        end else if (r_count == PosFirst) begin
            in_kind = KIND_FIRST;
        end else if (r_count <= PosVersionEnd) begin
            in_kind = KIND_VERSION;
        end else if (r_count == PosDestLen) begin
            in_kind = KIND_DEST_LEN;
        end else if (r_count <= dest_end) begin
            in_kind = KIND_DEST_ID;
        end else if (r_count == src_len_pos) begin
            in_kind = KIND_SRC_LEN;
        end else if (r_count <= src_end) begin
            in_kind = KIND_SRC_ID;
        end else begin
            in_kind = KIND_TOKEN;
        end
    end

    // header field capture and error detection
    always_comb begin
        n_version  = r_version;
        n_dest_len = r_dest_len;
        n_src_len  = r_src_len;
        n_hdr_err  = r_hdr_err;
        n_oversize = r_oversize || (r_count >= PktMax);
        if (!hdr_err) begin
            if (r_count == PosFirst) begin
                if ((in_byte & LONG_HEADER_BIT) == 8'h00) begin
                    n_hdr_err[ERR_NOT_LONG] = 1'b1;
                end else if (in_byte[5:4] != RETRY_TYPE) begin
                    // packet type sits in bits five and four
                    n_hdr_err[ERR_NOT_RETRY] = 1'b1;
                end
            end else if (r_count <= PosVersionEnd) begin
                n_version = {r_version[23:0], in_byte};
            end else if (r_count == PosDestLen) begin
                n_dest_len = in_byte;
                if (in_byte > CidMax) begin
                    n_hdr_err[ERR_ID_TOO_LONG] = 1'b1;
                end
            end else if (r_count == src_len_pos) begin
                n_src_len = in_byte;
                if (in_byte > CidMax) begin
                    n_hdr_err[ERR_ID_TOO_LONG] = 1'b1;
                end
            end
        end
    end

    // status resolution from the held packet state
    assign hdr_need  = MinLen + dest_len_ext;
    assign full_need = hdr_need + src_len_ext + TagLen;

    always_comb begin
        stat_token = '0;
        if (r_count < MinLen) begin
            stat_code = ST_TOO_SHORT;
        end else if (r_hdr_err[ERR_NOT_LONG]) begin
            stat_code = ST_NOT_LONG;
        end else if (r_hdr_err[ERR_NOT_RETRY]) begin
            stat_code = ST_NOT_RETRY;
        end else if (r_hdr_err[ERR_ID_TOO_LONG]) begin
            stat_code = ST_ID_TOO_LONG;
        end else if (r_count < hdr_need) begin
            stat_code = ST_TOO_SHORT;
        end else if (r_count < full_need) begin
            stat_code = ST_TOO_SHORT;
        end else if (r_oversize) begin
            stat_code = ST_OVERSIZE;
        end else begin
            stat_code  = ST_OK;
            stat_token = 12'(r_count - full_need);
        end
    end

    // result word: flush tag or status, else the byte leaving the line
    always_comb begin
        o_res       = '0;
        o_res_valid = 1'b0;
        if (flush_step) begin
            o_res_valid = 1'b1;
            if (r_rem != '0) begin
                o_res.kind     = KIND_TAG;
                o_res.out_byte = r_line_byte[rem_idx];
            end else begin
                o_res.kind             = KIND_STATUS;
                o_res.version_word     = r_version;
                o_res.dest_id_length   = r_dest_len;
                o_res.source_id_length = r_src_len;
                o_res.token_length     = stat_token;
                o_res.status_code      = stat_code;
                o_res.last_result      = 1'b1;
            end
        end else if (o_take && (r_count >= TagLen)) begin
            o_res_valid    = 1'b1;
            o_res.kind     = r_line_kind[TAG_BYTES-1];
            o_res.out_byte = r_line_byte[TAG_BYTES-1];
        end
    end

    // packet state and flush sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_version  <= '0;
            r_dest_len <= '0;
            r_src_len  <= '0;
            r_hdr_err  <= '0;
            r_oversize <= 1'b0;
            r_flush    <= 1'b0;
            r_rem      <= '0;
        end else if (flush_step && (r_rem == '0)) begin
            // status delivered, back to the start of a packet
            r_count    <= '0;
            r_version  <= '0;
            r_dest_len <= '0;
            r_src_len  <= '0;
            r_hdr_err  <= '0;
            r_oversize <= 1'b0;
            r_flush    <= 1'b0;
            r_rem      <= '0;
        end else if (flush_step) begin
            r_rem <= r_rem - RemW'(1);
        end else if (o_take) begin
            r_count    <= new_len;
            r_version  <= n_version;
            r_dest_len <= n_dest_len;
            r_src_len  <= n_src_len;
            r_hdr_err  <= n_hdr_err;
            r_oversize <= n_oversize;
            if (i_word.last_byte) begin
                r_flush <= 1'b1;
                r_rem   <= (new_len >= TagLen) ? TagRem : RemW'(new_len);
            end
        end
    end

    // delay line shift
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_line_byte[0] <= in_byte;
            r_line_kind[0] <= in_kind;
            for (int i = 1; i < TAG_BYTES; i++) begin
                r_line_byte[i] <= r_line_byte[i-1];
                r_line_kind[i] <= r_line_kind[i-1];
            end
        end
    end

    // checks
    `RPHP_ASSERT(a_last_starts_flush, i_clk, i_rst_n, (o_take && i_word.last_byte) |=> r_flush, "last byte did not start the flush")
    `RPHP_ASSERT(a_status_clears, i_clk, i_rst_n, (o_res_valid && (o_res.kind == KIND_STATUS)) |=> ((r_count == '0) && !r_flush), "state not cleared after status")
    `RPHP_NEVER(a_one_header_error, i_clk, i_rst_n, !$onehot0(r_hdr_err), "more than one header error recorded")
    `RPHP_ASSERT(a_flush_bound, i_clk, i_rst_n, r_flush |-> (r_rem <= TagRem), "flush count beyond tag length")

endmodule

### hdl/rphp_out_reg.sv
// ----------------------------------------------------------------------------
// rphp_out_reg
// Result register; reloads in the same cycle the held word is taken.
// ----------------------------------------------------------------------------
module rphp_out_reg import rphp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_slot_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_res_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### hdl/retry_packet_header_parser.sv
// ----------------------------------------------------------------------------
// retry_packet_header_parser
// Streaming labeller for long-header Retry packets, one byte per word.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready with i_data_byte and i_last_byte.
// Output channel: o_out_valid / i_out_ready, one labelled word per transfer.
// Each byte is delayed by TAG_BYTES words: once the line is full, every
// accepted byte pushes the oldest one out as a labelled word. After the last
// byte, the held bytes (up to TAG_BYTES) come out as tag words, oldest first,
// followed by one status word with o_last_result high.
// A byte is first held in the input register; the word it releases is
// loaded into the output register in the same cycle the parse stage takes it.
// Throughput: one byte per cycle while inside a packet and the receiver
// keeps up, set by the single parse stage. The end of a packet holds the
// input for the flush, which sends each held tag byte and then the status word.
// Reset clears all packet state; the first byte after reset starts a packet.
// A stalled receiver holds the output register, and the input register then
// fills and drops o_in_ready; no word is lost or repeated.
// ----------------------------------------------------------------------------
module retry_packet_header_parser import rphp_pkg::*; #(
    parameter int unsigned MAX_CID_BYTES    = 20,
    parameter int unsigned TAG_BYTES        = 16,
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_version_word,
    output logic [7:0]  o_dest_id_length,
    output logic [7:0]  o_source_id_length,
    output logic [11:0] o_token_length,
    output logic [2:0]  o_status_code,
    output logic        o_last_result
);

    logic     word_valid;
    t_in_word word;
    logic     take;
    logic     slot_free;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    // input register
    rphp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_ready      (o_in_ready),
        .o_word_valid (word_valid),
        .o_word       (word),
        .i_take       (take)
    );

    // parse stage
    rphp_core #(
        .MAX_CID_BYTES    (MAX_CID_BYTES),
        .TAG_BYTES        (TAG_BYTES),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (word_valid),
        .i_word       (word),
        .i_slot_free  (slot_free),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result register
    rphp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (i_out_ready),
        .o_slot_free (slot_free),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    // result fields
    assign o_kind             = out_res.kind;
    assign o_out_byte         = out_res.out_byte;
    assign o_version_word     = out_res.version_word;
    assign o_dest_id_length   = out_res.dest_id_length;
    assign o_source_id_length = out_res.source_id_length;
    assign o_token_length     = out_res.token_length;
    assign o_status_code      = out_res.status_code;
    assign o_last_result      = out_res.last_result;

endmodule

### tb/sv/tb_retry_packet_header_parser.sv
// ----------------------------------------------------------------------------
// tb_retry_packet_header_parser
// Streams Retry packets byte by byte into the parser and checks every labelled
// word and status word against a cycle-free parser kept in the bench. Covers
// short packets, each header error, CID length limits, truncation and random
// well-formed traffic, with random gaps on both channels and one long output
// stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_retry_packet_header_parser;
    import rphp_pkg::*;

    localparam int unsigned TAG_BYTES        = 16;
    localparam int unsigned MAX_CID_BYTES    = 20;
    localparam int unsigned MAX_PACKET_BYTES = 2048;
    localparam int unsigned TOTAL_BYTES      = 260;
    localparam int unsigned HOLD_AT_WORD     = 150;
    localparam int unsigned HOLD_CYCLES      = 300;
    localparam int unsigned DRAIN_CYCLES     = 24;
    localparam int unsigned WATCHDOG_LIMIT   = 4000;
    localparam int unsigned COUNT_SAT        = 32'h7FFF_FFFF;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_data   = '0;
    logic        in_last   = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [3:0]  out_kind;
    logic [7:0]  out_byte;
    logic [31:0] out_version;
    logic [7:0]  out_dest_len;
    logic [7:0]  out_src_len;
    logic [11:0] out_token_len;
    logic [2:0]  out_status;
    logic        out_last;

    retry_packet_header_parser #(
        .MAX_CID_BYTES   (MAX_CID_BYTES),
        .TAG_BYTES       (TAG_BYTES),
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (in_data),
        .i_last_byte       (in_last),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_kind            (out_kind),
        .o_out_byte        (out_byte),
        .o_version_word    (out_version),
        .o_dest_id_length  (out_dest_len),
        .o_source_id_length(out_src_len),
        .o_token_length    (out_token_len),
        .o_status_code     (out_status),
        .o_last_result     (out_last)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    t_in_word    pending_words [$];
    t_result     expected_words [$];
    logic [7:0]  pkt_bytes [$];
    int unsigned fail_count    = 0;
    int unsigned words_checked = 0;
    int unsigned bytes_sent    = 0;
    int unsigned packets_sent  = 0;
    int unsigned status_seen [8];

    // ------------------------------------------------------------------------
    // parser shadow: delay line plus captured header fields
    // ------------------------------------------------------------------------
    logic [7:0]       line_bytes [TAG_BYTES];
    int unsigned      line_wr;
    int unsigned      seen_count;
    logic [31:0]      cap_version;
    logic [7:0]       cap_dest_len;
    logic [7:0]       cap_src_len;
    logic [ERR_W-1:0] hdr_err;
    int unsigned      hdr_err_pos;
    logic             over_limit;

    function automatic void clear_parse_state();
        foreach (line_bytes[i]) line_bytes[i] = '0;
        line_wr      = 0;
        seen_count   = 0;
        cap_version  = '0;
        cap_dest_len = '0;
        cap_src_len  = '0;
        hdr_err      = '0;
        hdr_err_pos  = 0;
        over_limit   = 1'b0;
    endfunction

    // label of the byte at packet position p
    function automatic t_kind label_at(int unsigned p);
        int unsigned dl;
        int unsigned sl;
        dl = cap_dest_len;
        sl = cap_src_len;
        if (p >= MAX_PACKET_BYTES) return KIND_DISCARD;
        if (hdr_err != '0 && p > hdr_err_pos) return KIND_DISCARD;
        if (p == 0) return KIND_FIRST;
        if (p <= 4) return KIND_VERSION;
        if (p == 5) return KIND_DEST_LEN;
        if (p <= 5 + dl) return KIND_DEST_ID;
        if (p == 6 + dl) return KIND_SRC_LEN;
        if (p <= 6 + dl + sl) return KIND_SRC_ID;
        return KIND_TOKEN;
    endfunction

    // header fields are captured as bytes enter the line, until an error
    function automatic void capture_header(int unsigned p, logic [7:0] b);
        int unsigned dl;
        dl = cap_dest_len;
        if (p >= MAX_PACKET_BYTES) over_limit = 1'b1;
        if (hdr_err != '0) return;
        if (p == 0) begin
            if ((b & LONG_HEADER_BIT) == '0) begin
                hdr_err[ERR_NOT_LONG] = 1'b1;
                hdr_err_pos = 0;
            end else if (b[5:4] != RETRY_TYPE) begin
                hdr_err[ERR_NOT_RETRY] = 1'b1;
                hdr_err_pos = 0;
            end
        end else if (p <= 4) begin
            cap_version = {cap_version[23:0], b};
        end else if (p == 5) begin
            cap_dest_len = b;
            if (b > MAX_CID_BYTES) begin
                hdr_err[ERR_ID_TOO_LONG] = 1'b1;
                hdr_err_pos = p;
            end
        end else if (p == 6 + dl) begin
            cap_src_len = b;
            if (b > MAX_CID_BYTES) begin
                hdr_err[ERR_ID_TOO_LONG] = 1'b1;
                hdr_err_pos = p;
            end
        end
    endfunction

    function automatic void push_byte_word(t_kind kind, logic [7:0] b);
        t_result r;
        r          = '0;
        r.kind     = kind;
        r.out_byte = b;
        expected_words.push_back(r);
    endfunction

    // one accepted byte: queue the words it releases
    function automatic void label_packet_byte(logic [7:0] b, logic last);
        int unsigned pos;
        int unsigned len;
        int unsigned held;
        int unsigned start;
        int unsigned dl;
        int unsigned sl;
        int unsigned tok;
        t_status     code;
        t_result     r;
        pos = seen_count;
        capture_header(pos, b);
        if (pos >= TAG_BYTES) push_byte_word(label_at(pos - TAG_BYTES), line_bytes[line_wr]);
        line_bytes[line_wr] = b;
        line_wr = (line_wr + 1) % TAG_BYTES;
        if (seen_count < COUNT_SAT) seen_count++;
        if (last) begin
            len   = seen_count;
            held  = len < TAG_BYTES ? len : TAG_BYTES;
            start = len >= TAG_BYTES ? line_wr : 0;
            dl    = cap_dest_len;
            sl    = cap_src_len;
            tok   = 0;
            // flush the held bytes as tag, oldest first
            for (int k = 0; k < held; k++) begin
                push_byte_word(KIND_TAG, line_bytes[(start + k) % TAG_BYTES]);
            end
            // status resolution order
            if (len < MIN_HEADER_BYTES) code = ST_TOO_SHORT;
            else if (hdr_err[ERR_NOT_LONG]) code = ST_NOT_LONG;
            else if (hdr_err[ERR_NOT_RETRY]) code = ST_NOT_RETRY;
            else if (hdr_err[ERR_ID_TOO_LONG]) code = ST_ID_TOO_LONG;
            else if (len < MIN_HEADER_BYTES + dl + sl + TAG_BYTES) code = ST_TOO_SHORT;
            else if (over_limit) code = ST_OVERSIZE;
            else begin
                code = ST_OK;
                tok  = len - (MIN_HEADER_BYTES + dl + sl) - TAG_BYTES;
            end
            r                  = '0;
            r.kind             = KIND_STATUS;
            r.version_word     = cap_version;
            r.dest_id_length   = cap_dest_len;
            r.source_id_length = cap_src_len;
            r.token_length     = tok[11:0];
            r.status_code      = code;
            r.last_result      = 1'b1;
            expected_words.push_back(r);
            clear_parse_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // packet building
    // ------------------------------------------------------------------------
    task automatic build_retry(int unsigned dl, int unsigned sl, int unsigned tok);
        logic [7:0] b;
        pkt_bytes.delete();
        b      = 8'($urandom);
        b      = b | LONG_HEADER_BIT;
        b[5:4] = RETRY_TYPE;
        pkt_bytes.push_back(b);
        repeat (4) pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'(dl));
        repeat (dl) pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'(sl));
        repeat (sl) pkt_bytes.push_back(8'($urandom));
        repeat (tok) pkt_bytes.push_back(8'($urandom));
        repeat (TAG_BYTES) pkt_bytes.push_back(8'($urandom));
    endtask

    task automatic queue_packet();
        t_in_word w;
        foreach (pkt_bytes[i]) begin
            w.data_byte = pkt_bytes[i];
            w.last_byte = (i == pkt_bytes.size() - 1);
            pending_words.push_back(w);
        end
        packets_sent++;
    endtask

    task automatic cut_packet(int unsigned keep);
        while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch at word %0d, %s: expected %0h, got %0h",
                 words_checked, what, want, got);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned pick;
        int unsigned dl;
        int unsigned sl;
        int unsigned tok;

        clear_parse_state();

        // single byte, flushed as tag
        pkt_bytes = '{8'hFF};
        queue_packet();
        // first byte without the long header bit
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_packet();
        // long header of a type other than Retry, version never captured
        pkt_bytes = '{8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02};
        queue_packet();
        // destination id length just over the limit
        pkt_bytes = '{8'hF0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h15, 8'h00};
        queue_packet();
        // one byte below the minimum header
        pkt_bytes = '{8'hF3, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00};
        queue_packet();

        // corner packets
        build_retry(0, 0, 0);
        queue_packet();
        build_retry(MAX_CID_BYTES, MAX_CID_BYTES, 3);
        queue_packet();
        // destination id length over the limit, rest discarded
        build_retry(MAX_CID_BYTES + 1, 0, 4);
        cut_packet(12);
        queue_packet();
        build_retry(3, MAX_CID_BYTES + 1, 2);
        queue_packet();
        // largest source id length byte, rest discarded
        build_retry(3, 255, 0);
        cut_packet(24);
        queue_packet();
        // truncated inside the destination id
        build_retry(8, 4, 0);
        cut_packet(10);
        queue_packet();
        // truncated inside the tag
        build_retry(2, 2, 5);
        cut_packet(pkt_bytes.size() - 1);
        queue_packet();

        // random packets, mostly well formed
        while (pending_words.size() < TOTAL_BYTES) begin
            pick = $urandom_range(0, 9);
            dl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_CID_BYTES)
                                               : $urandom_range(0, 4);
            sl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_CID_BYTES)
                                               : $urandom_range(0, 4);
            tok  = $urandom_range(0, 12);
            build_retry(dl, sl, tok);
            if (pick == 6) begin
                // truncated anywhere
                cut_packet($urandom_range(1, pkt_bytes.size() - 1));
            end else if (pick == 7) begin
                // oversized id length on either field
                if ($urandom_range(0, 1) == 1)
                    pkt_bytes[5] = 8'($urandom_range(MAX_CID_BYTES + 1, 255));
                else
                    pkt_bytes[6 + dl] = 8'($urandom_range(MAX_CID_BYTES + 1, 255));
            end else if (pick == 8) begin
                // broken first byte
                if ($urandom_range(0, 1) == 1)
                    pkt_bytes[0][7] = 1'b0;
                else
                    pkt_bytes[0][5:4] = 2'($urandom_range(0, 2));
            end else if (pick == 9) begin
                // raw noise
                pkt_bytes.delete();
                repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
            end
            queue_packet();
        end

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (pending_words.size() != 0 || in_valid) @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d packets, %0d bytes, %0d result words checked, %0d mismatches",
                 packets_sent, bytes_sent, words_checked, fail_count);
        $display("status mix: ok %0d, short %0d, not long %0d, not retry %0d, %s %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_SHORT], status_seen[ST_NOT_LONG],
                 status_seen[ST_NOT_RETRY], "id too long", status_seen[ST_ID_TOO_LONG],
                 "oversize", status_seen[ST_OVERSIZE]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // input driver, random gaps with gap-free stretches
    // ------------------------------------------------------------------------
    int unsigned tx_wait  = 0;
    int unsigned tx_count = 0;

    always @(posedge clk) begin
        t_in_word w;
        logic     take;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_last  <= 1'b0;
        end else begin
            take = in_valid && in_ready;
            if (take) begin
                label_packet_byte(in_data, in_last);
                bytes_sent++;
            end
            if (!in_valid || take) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    in_data  <= w.data_byte;
                    in_last  <= w.last_byte;
                    in_valid <= 1'b1;
                    tx_count++;
                    tx_wait = ((tx_count / 48) % 3 == 1) ? 0 : $urandom_range(0, 11);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output receiver, random stalls and one long hold-off
    // ------------------------------------------------------------------------
    int unsigned rx_wait  = 0;
    int unsigned rx_words = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                rx_words++;
                if (rx_words == HOLD_AT_WORD)
                    rx_wait = HOLD_CYCLES;
                else
                    rx_wait = ((rx_words / 40) % 3 == 0) ? 0 : $urandom_range(0, 11);
            end
            if (rx_wait != 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                report_mismatch("word with none expected, kind", '0, out_kind);
            end else begin
                want = expected_words.pop_front();
                if (out_kind !== want.kind)
                    report_mismatch("kind", want.kind, out_kind);
                if (out_byte !== want.out_byte)
                    report_mismatch("byte", want.out_byte, out_byte);
                if (out_version !== want.version_word)
                    report_mismatch("version", want.version_word, out_version);
                if (out_dest_len !== want.dest_id_length)
                    report_mismatch("dest id length", want.dest_id_length, out_dest_len);
                if (out_src_len !== want.source_id_length)
                    report_mismatch("source id length", want.source_id_length, out_src_len);
                if (out_token_len !== want.token_length)
                    report_mismatch("token length", want.token_length, out_token_len);
                if (out_status !== want.status_code)
                    report_mismatch("status", want.status_code, out_status);
                if (out_last !== want.last_result)
                    report_mismatch("last", want.last_result, out_last);
                if (want.kind == KIND_STATUS) status_seen[want.status_code]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog on handshake activity
    // ------------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d words still expected",
                         idle_cycles, expected_words.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
